// ===== rtl/core/o2arc_pkg.sv =====
`timescale 1ns / 1ps

package o2arc_pkg;

   localparam int CfgW   = 20;
   localparam int CurW   = 15;
   localparam int PpmW   = 18;
   localparam int CodeW  = 3;
   localparam int DiffW  = 16;
   localparam int SpanW  = 21;
   localparam int ProdW  = 37;
   localparam int BaseW  = 34;
   localparam int SumW   = 38;
   localparam int QuotW  = 25;
   localparam int RecipW = 26;
   localparam int MulW   = 50;

   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_COARSE = 5'b00010,
      ST_FINE   = 5'b00100,
      ST_TEST   = 5'b01000,
      ST_ERROR  = 5'b10000
   } mode_type;

   localparam logic [CodeW-1:0] MODE_CODE_INIT   = 3'd0;
   localparam logic [CodeW-1:0] MODE_CODE_COARSE = 3'd1;
   localparam logic [CodeW-1:0] MODE_CODE_FINE   = 3'd2;
   localparam logic [CodeW-1:0] MODE_CODE_TEST   = 3'd3;
   localparam logic [CodeW-1:0] MODE_CODE_ERROR  = 3'd4;

   localparam logic [2:0] REG_COARSE_LOW       = 3'd0;
   localparam logic [2:0] REG_COARSE_HIGH      = 3'd1;
   localparam logic [2:0] REG_FINE_LOW         = 3'd2;
   localparam logic [2:0] REG_FINE_HIGH        = 3'd3;
   localparam logic [2:0] REG_FILTER_LOW       = 3'd4;
   localparam logic [2:0] REG_FILTER_HIGH      = 3'd5;
   localparam logic [2:0] REG_SWITCH_THRESHOLD = 3'd6;

   localparam logic [CfgW-1:0] RST_COARSE_LOW       = 20'd0;
   localparam logic [CfgW-1:0] RST_COARSE_HIGH      = 20'd250000;
   localparam logic [CfgW-1:0] RST_FINE_LOW         = 20'd0;
   localparam logic [CfgW-1:0] RST_FINE_HIGH        = 20'd1000;
   localparam logic [CfgW-1:0] RST_FILTER_LOW       = 20'd0;
   localparam logic [CfgW-1:0] RST_FILTER_HIGH      = 20'd250000;
   localparam logic [CfgW-1:0] RST_SWITCH_THRESHOLD = 20'd1000;

   localparam logic signed [DiffW-1:0] ZERO_UA   = 16'sd4000;
   localparam logic signed [SumW-1:0]  SAT_LIMIT = 38'sd4000016000;
   localparam logic [QuotW-1:0]        X_SAT     = 25'd31250000;
   localparam logic [RecipW-1:0]       RECIP_125 = 26'd34359739;
   localparam logic [PpmW-1:0]         PPM_MAX   = 18'd250000;

   function automatic logic [CodeW-1:0] mode_code(input mode_type m);
      logic [CodeW-1:0] c;
      unique case (m)
         ST_INIT:   c = MODE_CODE_INIT;
         ST_COARSE: c = MODE_CODE_COARSE;
         ST_FINE:   c = MODE_CODE_FINE;
         ST_TEST:   c = MODE_CODE_TEST;
         default:   c = MODE_CODE_ERROR;
      endcase
      return c;
   endfunction

   function automatic logic [BaseW-1:0] times_16000(input logic [CfgW-1:0] v);
      return {v, 14'b0} - BaseW'({v, 8'b0}) - BaseW'({v, 7'b0});
   endfunction

endpackage

// ===== rtl/core/oxygen_sensor_autorange_controller_core.sv =====
`timescale 1ns / 1ps

// A request is registered in turn by the input, product, control and divide stages.
// Throughput: one request per clock cycle; the input, product, control and divide
// stages each hold one request and stall only where the next stage is full.
// The mode register and range switch are updated once per request, in the control stage.
// Reset is synchronous and active high: it empties the pipeline, returns the controller
// to init with the coarse range and loads the default calibration registers.
module oxygen_sensor_autorange_controller_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // chamber_current_ua[14:0], filter_current_ua[29:15], chamber_fault[30],
   // filter_fault[31], test_request[32], zero padding above
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // mode[2:0], fine_range_select[3], chamber_ppm[21:4], filter_ppm[39:22],
   // readings_valid[40], test_accepted[41], zero padding above
   output logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CfgW  = o2arc_pkg::CfgW;
   localparam int CurW  = o2arc_pkg::CurW;
   localparam int PpmW  = o2arc_pkg::PpmW;
   localparam int CodeW = o2arc_pkg::CodeW;
   localparam int DiffW = o2arc_pkg::DiffW;
   localparam int SpanW = o2arc_pkg::SpanW;
   localparam int ProdW = o2arc_pkg::ProdW;
   localparam int BaseW = o2arc_pkg::BaseW;
   localparam int SumW  = o2arc_pkg::SumW;
   localparam int QuotW = o2arc_pkg::QuotW;
   localparam int MulW  = o2arc_pkg::MulW;

   function automatic logic [QuotW-1:0] clamp_x(input logic signed [SumW-1:0] v);
      logic [QuotW-1:0] x;
      if (v <= 0) begin
         x = '0;
      end else if (v >= o2arc_pkg::SAT_LIMIT) begin
         x = o2arc_pkg::X_SAT;
      end else begin
         x = v[31:7];
      end
      return x;
   endfunction

   // Configuration registers
   logic [CfgW-1:0] coarse_low_ff, coarse_high_ff, fine_low_ff, fine_high_ff;
   logic [CfgW-1:0] filter_low_ff, filter_high_ff, threshold_ff;
   logic [2:0]      csr_index;
   logic            csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coarse_low_ff  <= o2arc_pkg::RST_COARSE_LOW;
         coarse_high_ff <= o2arc_pkg::RST_COARSE_HIGH;
         fine_low_ff    <= o2arc_pkg::RST_FINE_LOW;
         fine_high_ff   <= o2arc_pkg::RST_FINE_HIGH;
         filter_low_ff  <= o2arc_pkg::RST_FILTER_LOW;
         filter_high_ff <= o2arc_pkg::RST_FILTER_HIGH;
         threshold_ff   <= o2arc_pkg::RST_SWITCH_THRESHOLD;
      end else if (csr_write) begin
         unique case (csr_index)
            o2arc_pkg::REG_COARSE_LOW:       coarse_low_ff  <= csr_pwdata[CfgW-1:0];
            o2arc_pkg::REG_COARSE_HIGH:      coarse_high_ff <= csr_pwdata[CfgW-1:0];
            o2arc_pkg::REG_FINE_LOW:         fine_low_ff    <= csr_pwdata[CfgW-1:0];
            o2arc_pkg::REG_FINE_HIGH:        fine_high_ff   <= csr_pwdata[CfgW-1:0];
            o2arc_pkg::REG_FILTER_LOW:       filter_low_ff  <= csr_pwdata[CfgW-1:0];
            o2arc_pkg::REG_FILTER_HIGH:      filter_high_ff <= csr_pwdata[CfgW-1:0];
            o2arc_pkg::REG_SWITCH_THRESHOLD: threshold_ff   <= csr_pwdata[CfgW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         o2arc_pkg::REG_COARSE_LOW:       csr_prdata = 32'(coarse_low_ff);
         o2arc_pkg::REG_COARSE_HIGH:      csr_prdata = 32'(coarse_high_ff);
         o2arc_pkg::REG_FINE_LOW:         csr_prdata = 32'(fine_low_ff);
         o2arc_pkg::REG_FINE_HIGH:        csr_prdata = 32'(fine_high_ff);
         o2arc_pkg::REG_FILTER_LOW:       csr_prdata = 32'(filter_low_ff);
         o2arc_pkg::REG_FILTER_HIGH:      csr_prdata = 32'(filter_high_ff);
         o2arc_pkg::REG_SWITCH_THRESHOLD: csr_prdata = 32'(threshold_ff);
         default:                         csr_prdata = '0;
      endcase
   end

   // Spans and offsets are registered from the calibration registers, updated in the cycle after a write.
   logic signed [SpanW-1:0] coarse_span_ff, fine_span_ff, filter_span_ff;
   logic signed [SpanW-1:0] coarse_span_in, fine_span_in, filter_span_in;
   logic [BaseW-1:0]        coarse_base_ff, fine_base_ff, filter_base_ff, threshold_base_ff;
   logic [BaseW-1:0]        coarse_base_in, fine_base_in, filter_base_in, threshold_base_in;

   assign coarse_span_in    = $signed({1'b0, coarse_high_ff}) - $signed({1'b0, coarse_low_ff});
   assign fine_span_in      = $signed({1'b0, fine_high_ff}) - $signed({1'b0, fine_low_ff});
   assign filter_span_in    = $signed({1'b0, filter_high_ff}) - $signed({1'b0, filter_low_ff});
   assign coarse_base_in    = o2arc_pkg::times_16000(coarse_low_ff);
   assign fine_base_in      = o2arc_pkg::times_16000(fine_low_ff);
   assign filter_base_in    = o2arc_pkg::times_16000(filter_low_ff);
   assign threshold_base_in = o2arc_pkg::times_16000(threshold_ff);

   always_ff @(posedge clock) begin
      coarse_span_ff    <= coarse_span_in;
      fine_span_ff      <= fine_span_in;
      filter_span_ff    <= filter_span_in;
      coarse_base_ff    <= coarse_base_in;
      fine_base_ff      <= fine_base_in;
      filter_base_ff    <= filter_base_in;
      threshold_base_ff <= threshold_base_in;
   end

   // Stage handshake
   logic a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;
   logic a_ready, b_ready, c_ready, out_ready;

   assign out_ready  = ~rsp_valid_ff | rsp_tready;
   assign c_ready    = ~c_valid_ff | out_ready;
   assign b_ready    = ~b_valid_ff | c_ready;
   assign a_ready    = ~a_valid_ff | b_ready;
   assign req_tready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= req_tvalid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= c_valid_ff;
         end
      end
   end

   // Input stage
   logic [CurW-1:0] a_ch_cur_ff, a_fi_cur_ff;
   logic            a_ch_fault_ff, a_fi_fault_ff, a_test_ff;

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_ch_cur_ff   <= req_tdata[14:0];
         a_fi_cur_ff   <= req_tdata[29:15];
         a_ch_fault_ff <= req_tdata[30];
         a_fi_fault_ff <= req_tdata[31];
         a_test_ff     <= req_tdata[32];
      end
   end

   // Product stage: both chamber ranges are multiplied so the mode is needed only later.
   logic signed [DiffW-1:0] ch_diff, fi_diff;
   logic signed [ProdW-1:0] b_prod_coarse_in, b_prod_fine_in, b_prod_fi_in;
   logic signed [ProdW-1:0] b_prod_coarse_ff, b_prod_fine_ff, b_prod_fi_ff;
   logic                    b_ch_fault_ff, b_fi_fault_ff, b_test_ff;

   assign ch_diff          = $signed({1'b0, a_ch_cur_ff}) - o2arc_pkg::ZERO_UA;
   assign fi_diff          = $signed({1'b0, a_fi_cur_ff}) - o2arc_pkg::ZERO_UA;
   assign b_prod_coarse_in = ProdW'(ch_diff) * ProdW'(coarse_span_ff);
   assign b_prod_fine_in   = ProdW'(ch_diff) * ProdW'(fine_span_ff);
   assign b_prod_fi_in     = ProdW'(fi_diff) * ProdW'(filter_span_ff);

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_prod_coarse_ff <= b_prod_coarse_in;
         b_prod_fine_ff   <= b_prod_fine_in;
         b_prod_fi_ff     <= b_prod_fi_in;
         b_ch_fault_ff    <= a_ch_fault_ff;
         b_fi_fault_ff    <= a_fi_fault_ff;
         b_test_ff        <= a_test_ff;
      end
   end

   // Control stage: mode update, range decision and clamping.
   o2arc_pkg::mode_type     mode_ff, mode_in;
   logic                    range_ff, range_in;
   logic                    c_step;
   logic                    both_fault, healthy, measuring, above;
   logic signed [ProdW-1:0] ch_prod;
   logic [BaseW-1:0]        ch_base;
   logic signed [SumW-1:0]  sum_ch, sum_fi;
   logic [CodeW-1:0]        c_code_ff;
   logic                    c_range_ff, c_readings_ff, c_acc_ff;
   logic                    c_readings_in, c_acc_in;
   logic [QuotW-1:0]        c_x_ch_ff, c_x_fi_ff, c_x_ch_in, c_x_fi_in;

   assign c_step     = b_valid_ff & c_ready;
   assign both_fault = b_ch_fault_ff & b_fi_fault_ff;
   assign healthy    = ~b_ch_fault_ff & ~b_fi_fault_ff;
   assign measuring  = (mode_ff == o2arc_pkg::ST_COARSE) | (mode_ff == o2arc_pkg::ST_FINE);
   assign ch_prod    = (mode_ff == o2arc_pkg::ST_FINE) ? b_prod_fine_ff : b_prod_coarse_ff;
   assign ch_base    = (mode_ff == o2arc_pkg::ST_FINE) ? fine_base_ff : coarse_base_ff;
   assign sum_ch     = $signed({4'b0, ch_base}) + SumW'(ch_prod);
   assign sum_fi     = $signed({4'b0, filter_base_ff}) + SumW'(b_prod_fi_ff);
   assign above      = sum_ch >= $signed({4'b0, threshold_base_ff});

   always_comb begin
      mode_in       = mode_ff;
      range_in      = range_ff;
      c_readings_in = 1'b0;
      c_acc_in      = 1'b0;
      c_x_ch_in     = '0;
      c_x_fi_in     = '0;
      unique case (mode_ff)
         o2arc_pkg::ST_INIT: begin
            range_in = 1'b0;
            mode_in  = healthy ? o2arc_pkg::ST_COARSE : o2arc_pkg::ST_ERROR;
         end
         o2arc_pkg::ST_COARSE, o2arc_pkg::ST_FINE: begin
            c_readings_in = 1'b1;
            c_x_ch_in     = clamp_x(sum_ch);
            c_x_fi_in     = clamp_x(sum_fi);
            range_in      = ~above;
            mode_in       = above ? o2arc_pkg::ST_COARSE : o2arc_pkg::ST_FINE;
            if (b_test_ff) begin
               mode_in  = o2arc_pkg::ST_TEST;
               c_acc_in = 1'b1;
            end
            if (both_fault) begin
               mode_in = o2arc_pkg::ST_ERROR;
            end
         end
         o2arc_pkg::ST_TEST: begin
            mode_in = both_fault ? o2arc_pkg::ST_ERROR : o2arc_pkg::ST_INIT;
         end
         default: begin
            mode_in = healthy ? o2arc_pkg::ST_INIT : o2arc_pkg::ST_ERROR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= o2arc_pkg::ST_INIT;
         range_ff <= 1'b0;
      end else if (c_step) begin
         mode_ff  <= mode_in;
         range_ff <= range_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready) begin
         c_code_ff     <= o2arc_pkg::mode_code(mode_in);
         c_range_ff    <= range_in;
         c_readings_ff <= c_readings_in;
         c_acc_ff      <= c_acc_in;
         c_x_ch_ff     <= c_x_ch_in;
         c_x_fi_ff     <= c_x_fi_in;
      end
   end

   // Divide stage: the quotient by 125 is exact for every value below the saturation point.
   logic [MulW-1:0]  mul_ch, mul_fi;
   logic [PpmW-1:0]  rsp_ch_ppm_in, rsp_fi_ppm_in, rsp_ch_ppm_ff, rsp_fi_ppm_ff;
   logic [CodeW-1:0] rsp_code_ff;
   logic             rsp_range_ff, rsp_readings_ff, rsp_acc_ff;

   assign mul_ch        = MulW'(c_x_ch_ff) * MulW'(o2arc_pkg::RECIP_125);
   assign mul_fi        = MulW'(c_x_fi_ff) * MulW'(o2arc_pkg::RECIP_125);
   assign rsp_ch_ppm_in = mul_ch[49:32];
   assign rsp_fi_ppm_in = mul_fi[49:32];

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_code_ff     <= c_code_ff;
         rsp_range_ff    <= c_range_ff;
         rsp_readings_ff <= c_readings_ff;
         rsp_acc_ff      <= c_acc_ff;
         rsp_ch_ppm_ff   <= rsp_ch_ppm_in;
         rsp_fi_ppm_ff   <= rsp_fi_ppm_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_acc_ff, rsp_readings_ff, rsp_fi_ppm_ff, rsp_ch_ppm_ff,
                        rsp_range_ff, rsp_code_ff};

   // Readings are only produced by a request that passed through a measuring state.
   a_readings_mode : assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && c_readings_ff |->
         (c_code_ff == o2arc_pkg::MODE_CODE_COARSE || c_code_ff == o2arc_pkg::MODE_CODE_FINE
          || c_code_ff == o2arc_pkg::MODE_CODE_TEST || c_code_ff == o2arc_pkg::MODE_CODE_ERROR))
      else $error("readings produced by a request that left from init");

   // The controller state moves only when a request passes the control stage.
   a_mode_hold : assert property (@(posedge clock) disable iff (reset)
      !c_step |=> $stable(mode_ff) && $stable(range_ff))
      else $error("mode changed without a request");

   // An accepted test leaves the controller in test or error.
   a_test_taken : assert property (@(posedge clock) disable iff (reset)
      c_step && measuring && b_test_ff |=>
         (mode_ff == o2arc_pkg::ST_TEST || mode_ff == o2arc_pkg::ST_ERROR))
      else $error("accepted test request did not reach test or error");

   // Clamped readings never exceed full scale.
   a_ppm_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ch_ppm_ff <= o2arc_pkg::PPM_MAX && rsp_fi_ppm_ff <= o2arc_pkg::PPM_MAX)
      else $error("reading above full scale");

endmodule
